@@ rtl/assert_macros.svh @@
// assertion macros shared by the checker files
// no dependencies; included by name where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while the active-low reset is asserted
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// same, on the default clock and reset names of this project
`define ASSERT_DEF(name, prop, msg) \
  `ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/bdts_pkg.sv @@
// types and constants of the byte translate / delete / squeeze unit
// no dependencies; used by the interfaces and all modules
package bdts_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TBL_DEPTH  = 256;
  localparam int unsigned TBL_IDX_W  = 8;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // request codes
  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // register indexes (paddr bit 2)
  localparam logic CFG_IDX_DELETE  = 1'b0;
  localparam logic CFG_IDX_SQUEEZE = 1'b1;

  typedef struct packed {
    logic                mark;
    logic [BYTE_W-1:0]   value;
  } map_entry_t;

  typedef struct packed {
    logic delete_mode;
    logic squeeze_enable;
  } cfg_t;

endpackage

@@ rtl/bdts_if.sv @@
// stream interfaces of the unit: input requests and result items
// depends on bdts_pkg
interface bdts_in_if;
  import bdts_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [BYTE_W-1:0] byte_value;
  logic [BYTE_W-1:0] map_value;
  logic              map_mark;
  logic              end_of_string;

  modport source (
    output valid, req_type, byte_value, map_value, map_mark, end_of_string,
    input  ready
  );
  modport sink (
    input  valid, req_type, byte_value, map_value, map_mark, end_of_string,
    output ready
  );
endinterface

interface bdts_out_if;
  import bdts_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              keep;
  logic              string_end;

  modport source (
    output valid, out_byte, keep, string_end,
    input  ready
  );
  modport sink (
    input  valid, out_byte, keep, string_end,
    output ready
  );
endinterface

@@ rtl/byte_translate_delete_squeeze_unit.sv @@
// top level of the byte translate / delete / squeeze unit
// depends on bdts_pkg, bdts_if, bdts_map_mem and bdts_cfg_regs
//
//   channel   direction  handshake        transaction
//   in_i      sink       valid / ready    data byte or table entry write
//   out_o     source     valid / ready    one result per data byte
//   apb       slave      psel / penable   register write or read, pready tied high
//
// one item per cycle sustained while out_o is ready; a data byte reaches out_o through
// the lookup stage (table read) and then the output register
// table writes finish at their acceptance edge and give no transaction on out_o
// reset clears the mode registers, the string tracking and the table valid bits
// at once, so the unit takes items in the first cycle after reset
// in_i stalls only when both the lookup stage and a stalled output register are full
module byte_translate_delete_squeeze_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  bdts_in_if.sink                               in_i,
  bdts_out_if.source                            out_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [bdts_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [bdts_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [bdts_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                  pready
);
  import bdts_pkg::*;

  cfg_t              cfg;

  // handshake
  logic              in_acc;
  logic              data_acc;
  logic              write_acc;
  logic              out_free;

  // string tracking, updated in acceptance order
  logic              have_prev_q, have_prev_d;
  logic [BYTE_W-1:0] prev_byte_q, prev_byte_d;
  logic              sq_hit;

  // lookup stage: table read data arrives with these
  logic              s1_valid_q, s1_valid_d;
  logic [BYTE_W-1:0] s1_byte_q;
  logic              s1_eos_q;
  logic              s1_sq_hit_q;
  map_entry_t        rd_entry;

  // result computed from the table entry
  logic [BYTE_W-1:0] res_byte;
  logic              res_keep;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_keep_q;
  logic              out_end_q;

  bdts_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // output register takes a new result when empty or being drained
  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = !s1_valid_q || out_free;
  assign in_acc      = in_i.valid && in_i.ready;
  assign data_acc    = in_acc && (in_i.req_type == REQ_DATA);
  assign write_acc   = in_acc && (in_i.req_type == REQ_WRITE);

  // a write lands at its acceptance edge, so a data byte accepted in the
  // next cycle already reads the new entry: no forwarding needed
  bdts_map_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (write_acc),
    .wr_addr_i (in_i.byte_value),
    .wr_data_i ('{mark: in_i.map_mark, value: in_i.map_value}),
    .rd_en_i   (data_acc),
    .rd_addr_i (in_i.byte_value),
    .rd_data_o (rd_entry)
  );

  // squeeze check against the previous byte of the same string
  assign sq_hit = cfg.squeeze_enable && have_prev_q && (prev_byte_q == in_i.byte_value);

  always_comb begin
    have_prev_d = have_prev_q;
    prev_byte_d = prev_byte_q;
    if (data_acc) begin
      if (in_i.end_of_string) begin
        have_prev_d = 1'b0;
        prev_byte_d = '0;
      end else begin
        have_prev_d = 1'b1;
        prev_byte_d = in_i.byte_value;
      end
    end
  end

  // lookup stage occupancy
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (data_acc) begin
      s1_valid_d = 1'b1;
    end else if (out_free) begin
      s1_valid_d = 1'b0;
    end
  end

  // delete mode drops marked bytes; translate mode swaps marked bytes and
  // may squeeze repeats
  always_comb begin
    if (cfg.delete_mode) begin
      res_byte = s1_byte_q;
      res_keep = !rd_entry.mark;
    end else begin
      res_byte = rd_entry.mark ? rd_entry.value : s1_byte_q;
      res_keep = !s1_sq_hit_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_byte_q <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      have_prev_q <= have_prev_d;
      prev_byte_q <= prev_byte_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (data_acc) begin
      s1_byte_q   <= in_i.byte_value;
      s1_eos_q    <= in_i.end_of_string;
      s1_sq_hit_q <= sq_hit;
    end
    if (out_free && s1_valid_q) begin
      out_byte_q <= res_byte;
      out_keep_q <= res_keep;
      out_end_q  <= s1_eos_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.keep       = out_keep_q;
  assign out_o.string_end = out_end_q;

endmodule

@@ rtl/bdts_map_mem.sv @@
// 256-entry map table: one write port, one registered read port
// depends on bdts_pkg; per-entry valid bits make unwritten entries read as zero
module bdts_map_mem (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 wr_en_i,
  input  logic [bdts_pkg::TBL_IDX_W-1:0]       wr_addr_i,
  input  bdts_pkg::map_entry_t                 wr_data_i,
  input  logic                                 rd_en_i,
  input  logic [bdts_pkg::TBL_IDX_W-1:0]       rd_addr_i,
  output bdts_pkg::map_entry_t                 rd_data_o
);
  import bdts_pkg::*;

  map_entry_t             mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0]   vld_q;
  map_entry_t             rd_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

@@ rtl/bdts_cfg_regs.sv @@
// configuration registers behind the apb-style port
// depends on bdts_pkg; delivers the mode bits as a cfg_t struct
module bdts_cfg_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [bdts_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [bdts_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [bdts_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                  pready,
  output bdts_pkg::cfg_t                        cfg_o
);
  import bdts_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        CFG_IDX_DELETE:  cfg_d.delete_mode    = pwdata[0];
        CFG_IDX_SQUEEZE: cfg_d.squeeze_enable = pwdata[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      CFG_IDX_DELETE:  prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_q.delete_mode};
      CFG_IDX_SQUEEZE: prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_q.squeeze_enable};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/bdts_checker.sv @@
// port-level checker for the byte translate / delete / squeeze unit
// depends on bdts_pkg and assert_macros.svh; bound to the top level below
`include "assert_macros.svh"

module bdts_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          in_req_type_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [bdts_pkg::BYTE_W-1:0]   out_byte_i,
  input logic                          out_keep_i,
  input logic                          out_end_i
);
  import bdts_pkg::*;

  logic in_data_acc;

  assign in_data_acc = in_valid_i && in_ready_i && (in_req_type_i == REQ_DATA);

  // a stalled result holds
  `ASSERT_DEF(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_keep_i) && $stable(out_end_i), "stalled result changed")

  // a result appearing on an idle output comes from a data byte that passed the lookup stage
  `ASSERT_DEF(a_out_origin, $rose(out_valid_i) |-> $past(in_data_acc, 2), "result without data transaction")

  // no back-pressure on the input while the output is empty
  `ASSERT_DEF(a_in_ready, !out_valid_i |-> in_ready_i, "input stalled with empty output")

endmodule

bind byte_translate_delete_squeeze_unit bdts_checker u_bdts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_req_type_i (in_i.req_type),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .out_keep_i    (out_o.keep),
  .out_end_i     (out_o.string_end)
);
